// File: design/bdc_pkg.sv
// Shared constants, span descriptor type and line cost function for the DRAM byte counter.
`default_nettype none

package bdc_pkg;

    localparam int BUS_BYTES           = 16;
    localparam int BURST_BEATS         = 16;
    localparam int SPECIAL_BURST_BEATS = 1;
    localparam int PAGE_BYTES          = 4096;
    localparam int LINE_BYTES          = 64;
    localparam int ADDR_BITS           = 42;
    localparam int SIZE_BITS           = 24;
    localparam int MODE_BITS           = 2;
    localparam int OUT_BITS            = 25;
    localparam int RANGE_ALIGN         = 16;

    localparam logic [MODE_BITS-1:0] CW_TRANSPOSE = MODE_BITS'(3);
    localparam logic [OUT_BITS-1:0]  OUT_MAX      = '1;

    localparam int BSZ_NORM  = BUS_BYTES * BURST_BEATS;
    localparam int BSZ_SPEC  = BUS_BYTES * SPECIAL_BURST_BEATS;
    localparam int BSZ_MAX   = (BSZ_NORM > BSZ_SPEC) ? BSZ_NORM : BSZ_SPEC;

    localparam int LINE_LB   = $clog2(LINE_BYTES);
    localparam int BUS_LB    = $clog2(BUS_BYTES);
    localparam int PAGE_LB   = $clog2(PAGE_BYTES);
    localparam int RALIGN_LB = $clog2(RANGE_ALIGN);
    localparam int BSZN_LB   = $clog2(BSZ_NORM);
    localparam int BSZS_LB   = $clog2(BSZ_SPEC);

    localparam int LEN_W = SIZE_BITS + 1;
    localparam int BSZ_W = $clog2(BSZ_MAX) + 1;
    localparam int CST_W = ((BSZ_W > LINE_LB) ? BSZ_W : LINE_LB) + 2;
    localparam int K_W   = LINE_LB + 1;
    localparam int SP_W  = CST_W + K_W;
    localparam int ACC_W = LEN_W + SP_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // The line size is a power of two, so the gcd with it is the lowest set bit of step.
    function automatic int line_gcd(input int step);
        int g;
        g = LINE_BYTES;
        for (int i = 30; i >= 0; i--) begin
            if (step[i]) begin
                g = 1 << i;
            end
        end
        return g;
    endfunction

    localparam int STEP_NORM = BSZ_NORM % LINE_BYTES;
    localparam int STEP_SPEC = BSZ_SPEC % LINE_BYTES;
    localparam int P_NORM    = LINE_BYTES / line_gcd(STEP_NORM);
    localparam int P_SPEC    = LINE_BYTES / line_gcd(STEP_SPEC);
    localparam int LOGP_NORM = $clog2(P_NORM);
    localparam int LOGP_SPEC = $clog2(P_SPEC);

    typedef struct packed {
        logic [LINE_LB-1:0] ofs;
        logic [LEN_W-1:0]   len;
        logic               spec;
        logic               last;
    } t_span;

    // Bytes of all lines touched by a burst that starts at offset ofs within its line.
    function automatic logic [CST_W-1:0] line_cost(input logic [LINE_LB-1:0] ofs,
                                                   input logic [BSZ_W-1:0] len);
        logic [CST_W-1:0] s;
        s = CST_W'(ofs) + CST_W'(len) + CST_W'(LINE_BYTES - 1);
        return {s[CST_W-1:LINE_LB], LINE_LB'(0)};
    endfunction

endpackage

`default_nettype wire

// File: design/bdc_front.sv
// Front end: accepts a transfer, splits it at the page boundary and queues its spans.
`default_nettype none

module bdc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [bdc_pkg::ADDR_BITS-1:0]   i_base_addr,
    input  logic [bdc_pkg::SIZE_BITS-1:0]   i_transfer_size,
    input  logic [bdc_pkg::MODE_BITS-1:0]   i_transpose_mode,
    input  logic                            i_is_store,
    input  logic                            i_q_full,
    output logic                            o_push,
    output bdc_pkg::t_span                  o_span,
    output logic                            o_busy
);
    import bdc_pkg::*;

    localparam int EW = ADDR_BITS + 1;

    logic [1:0]         r_left, n_left;
    t_span              r_cur, n_cur, r_nxt, n_nxt;
    logic [EW-1:0]      w_end;
    logic [PAGE_LB-1:0] w_lowp;
    logic               w_cross, w_head, w_spec, w_acc, w_push;
    logic [LEN_W-1:0]   w_hlen;
    logic [LINE_LB-1:0] w_ofs;
    t_span              w_headspan, w_tailspan, w_single;

    always_comb begin
        w_end   = {1'b0, i_base_addr} + EW'(i_transfer_size);
        w_cross = {1'b0, i_base_addr[ADDR_BITS-1:PAGE_LB]} != w_end[EW-1:PAGE_LB];
        w_lowp  = i_base_addr[PAGE_LB-1:0];
        w_head  = w_lowp != '0;
        w_hlen  = w_head ? (LEN_W'(PAGE_BYTES) - LEN_W'(w_lowp)) : '0;
        w_spec  = (i_transpose_mode == CW_TRANSPOSE) && i_is_store;
        w_ofs   = {i_base_addr[LINE_LB-1:BUS_LB], BUS_LB'(0)};

        w_headspan = '{ofs: w_ofs, len: w_hlen, spec: w_spec, last: 1'b0};
        w_tailspan = '{ofs: '0, len: LEN_W'(i_transfer_size) - w_hlen, spec: w_spec,
                       last: 1'b1};
        w_single   = '{ofs: w_ofs,
                       len: LEN_W'(i_transfer_size) + LEN_W'(i_base_addr[RALIGN_LB-1:0]),
                       spec: w_spec, last: 1'b1};

        w_acc  = i_start && (r_left == '0);
        w_push = (r_left != '0) && !i_q_full;

        n_left = r_left;
        n_cur  = r_cur;
        n_nxt  = r_nxt;
        if (w_push) begin
            n_cur  = r_nxt;
            n_left = r_left - 2'd1;
        end
        if (w_acc) begin
            if (w_cross && w_head) begin
                n_cur  = w_headspan;
                n_nxt  = w_tailspan;
                n_left = 2'd2;
            end else if (w_cross) begin
                n_cur  = w_tailspan;
                n_left = 2'd1;
            end else begin
                n_cur  = w_single;
                n_left = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_nxt <= n_nxt;
    end

    assign o_push = w_push;
    assign o_span = r_cur;
    assign o_busy = r_left != '0;

endmodule

`default_nettype wire

// File: design/bdc_queue.sv
// Short span queue between the front end and the back end.
`default_nettype none

module bdc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bdc_pkg::t_span i_wdata,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output bdc_pkg::t_span o_rdata
);
    import bdc_pkg::*;

    t_span             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [Q_AW:0]     r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_full  = r_cnt == (Q_AW + 1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_rdata = r_mem[r_rp];

endmodule

`default_nettype wire

// File: design/bdc_back.sv
// Back end: costs the bursts of each span in line phases and sums the spans of a transfer.
`default_nettype none

module bdc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  bdc_pkg::t_span                i_span,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [bdc_pkg::OUT_BITS-1:0]  o_dram_bytes
);
    import bdc_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_LOOP = 4'b0010,
        B_MUL  = 4'b0100,
        B_SUM  = 4'b1000
    } t_bstate;

    localparam logic [LEN_W-1:0] MASK_N = LEN_W'(BSZ_NORM - 1);
    localparam logic [LEN_W-1:0] MASK_S = LEN_W'(BSZ_SPEC - 1);

    t_bstate               r_state, n_state;
    logic [LINE_LB-1:0]    r_r, n_r, r_rrem, n_rrem;
    logic [K_W-1:0]        r_k, n_k;
    logic [SP_W-1:0]       r_sp, n_sp, r_sq, n_sq;
    logic [LEN_W-1:0]      r_n, n_n;
    logic [BSZ_W-1:0]      r_rem, n_rem;
    logic                  r_spec, n_spec, r_last, n_last;
    logic [ACC_W-1:0]      r_prod, n_prod, r_acc, n_acc;
    logic                  r_valid, n_valid;
    logic [OUT_BITS-1:0]   r_out, n_out;

    logic [K_W-1:0]        w_p, w_q;
    logic [BSZ_W-1:0]      w_bsz;
    logic [LINE_LB-1:0]    w_step;
    logic [CST_W-1:0]      w_c, w_rc;
    logic [LEN_W-1:0]      w_nq, w_rawrem, w_rnd;
    logic [LEN_W+SP_W-1:0] w_prod;
    logic [ACC_W-1:0]      w_sum;

    always_comb begin
        w_p     = r_spec ? K_W'(P_SPEC) : K_W'(P_NORM);
        w_q     = r_n[K_W-1:0] & (w_p - 1'b1);
        w_bsz   = r_spec ? BSZ_W'(BSZ_SPEC) : BSZ_W'(BSZ_NORM);
        w_step  = r_spec ? LINE_LB'(STEP_SPEC) : LINE_LB'(STEP_NORM);
        w_c     = line_cost(r_r, w_bsz);
        w_nq    = r_spec ? (r_n >> LOGP_SPEC) : (r_n >> LOGP_NORM);
        w_prod  = w_nq * r_sp;
        w_rc    = (r_rem != '0) ? line_cost(r_rrem, r_rem) : '0;
        w_sum   = r_acc + r_prod + ACC_W'(r_sq) + ACC_W'(w_rc);
        w_rawrem = i_span.len & (i_span.spec ? MASK_S : MASK_N);
        w_rnd    = w_rawrem + LEN_W'(BUS_BYTES - 1);

        n_state = r_state;
        n_r     = r_r;
        n_rrem  = r_rrem;
        n_k     = r_k;
        n_sp    = r_sp;
        n_sq    = r_sq;
        n_n     = r_n;
        n_rem   = r_rem;
        n_spec  = r_spec;
        n_last  = r_last;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_valid = 1'b0;
        n_out   = r_out;
        o_pop   = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_r     = i_span.ofs;
                    n_rrem  = i_span.ofs;
                    n_k     = '0;
                    n_sp    = '0;
                    n_sq    = '0;
                    n_n     = i_span.spec ? (i_span.len >> BSZS_LB)
                                          : (i_span.len >> BSZN_LB);
                    n_rem   = BSZ_W'({w_rnd[LEN_W-1:BUS_LB], BUS_LB'(0)});
                    n_spec  = i_span.spec;
                    n_last  = i_span.last;
                    n_state = B_LOOP;
                end
            end
            B_LOOP: begin
                n_sp = r_sp + SP_W'(w_c);
                if (r_k < w_q) begin
                    n_sq = r_sq + SP_W'(w_c);
                end
                if (r_k == w_q) begin
                    n_rrem = r_r;
                end
                n_r = r_r + w_step;
                n_k = r_k + 1'b1;
                if (r_k == w_p - 1'b1) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_prod  = ACC_W'(w_prod);
                n_state = B_SUM;
            end
            B_SUM: begin
                if (r_last) begin
                    n_valid = 1'b1;
                    n_out   = (w_sum > ACC_W'(OUT_MAX)) ? OUT_MAX : w_sum[OUT_BITS-1:0];
                    n_acc   = '0;
                end else begin
                    n_acc   = w_sum;
                end
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r    <= n_r;
        r_rrem <= n_rrem;
        r_k    <= n_k;
        r_sp   <= n_sp;
        r_sq   <= n_sq;
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_spec <= n_spec;
        r_last <= n_last;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign o_valid      = r_valid;
    assign o_dram_bytes = r_out;

endmodule

`default_nettype wire

// File: design/axi_burst_dram_byte_counter.sv
// Top level of the DRAM byte counter for one burst-split DMA transfer.
//
// A transfer word is presented on i_base_addr, i_transfer_size, i_transpose_mode and
// i_is_store with start high; it is taken at the clock edge where busy is low.
// The front end splits the transfer at a page boundary into one or two spans and
// writes them into a four-entry span queue, holding busy until its last span is
// written; a full queue holds the write back.
// The back end pops one span at a time and steps once per burst phase within a line:
// one phase for a normal burst, four for a CW-transpose store, then one multiply step
// and one sum step. The sum step adds each span to the running sum of its transfer;
// a transfer takes one or two spans.
// The result word appears on o_dram_bytes with o_valid high for exactly one cycle
// after the sum step of the last span; results leave in acceptance order.
// The receiver cannot stall; o_valid is a strobe only.
// A synchronous low i_rst_n empties the queue, clears the running sum and drops
// busy and o_valid at the next edge.
`default_nettype none

module axi_burst_dram_byte_counter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [bdc_pkg::ADDR_BITS-1:0]   i_base_addr,
    input  logic [bdc_pkg::SIZE_BITS-1:0]   i_transfer_size,
    input  logic [bdc_pkg::MODE_BITS-1:0]   i_transpose_mode,
    input  logic                            i_is_store,
    output logic                            busy,
    output logic                            o_valid,
    output logic [bdc_pkg::OUT_BITS-1:0]    o_dram_bytes
);
    import bdc_pkg::*;

    logic  w_push, w_pop, w_full, w_empty;
    t_span w_wspan, w_rspan;

    bdc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_base_addr      (i_base_addr),
        .i_transfer_size  (i_transfer_size),
        .i_transpose_mode (i_transpose_mode),
        .i_is_store       (i_is_store),
        .i_q_full         (w_full),
        .o_push           (w_push),
        .o_span           (w_wspan),
        .o_busy           (busy)
    );

    bdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wspan),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_rdata (w_rspan)
    );

    bdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_span       (w_rspan),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_dram_bytes (o_dram_bytes)
    );

endmodule

`default_nettype wire

// File: design/bdc_checker.sv
// Port-level checker for the DRAM byte counter and its bind to the top level.
`default_nettype none

module bdc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_valid,
    input  logic [bdc_pkg::OUT_BITS-1:0]  o_dram_bytes
);
    import bdc_pkg::*;

    logic [3:0] r_pend, n_pend;

    always_comb begin
        n_pend = r_pend;
        if ((start && !busy) && !o_valid) begin
            n_pend = r_pend + 4'd1;
        end else if (o_valid && !(start && !busy)) begin
            n_pend = r_pend - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted word");

    a_line_multiple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dram_bytes[LINE_LB-1:0] == '0 || o_dram_bytes == OUT_MAX))
        else $error("result is neither a whole number of lines nor saturated");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pend != '0))
        else $error("result word without an outstanding transfer");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("outputs active after reset");

endmodule

bind axi_burst_dram_byte_counter bdc_checker u_bdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_dram_bytes (o_dram_bytes)
);

`default_nettype wire

// File: verif/axi_burst_dram_byte_counter_tb.sv
// Self-checking testbench for the burst-split DRAM byte counter with a scoreboard class.
`default_nettype none

module axi_burst_dram_byte_counter_tb;
    import bdc_pkg::*;

    localparam int NUM_RANDOM = 1250;

    class dram_byte_board;
        logic [OUT_BITS-1:0] expected_bytes[$];
        int words_in;
        int words_out;
        int mismatches;
        int crossings;
        int cw_stores;
        int saturated;

        function longint unsigned lines_hit(longint unsigned ofs, longint unsigned len);
            return ((ofs + len + LINE_BYTES - 1) / LINE_BYTES) * LINE_BYTES;
        endfunction

        // Burst offsets within a line repeat every LINE_BYTES bursts at the latest.
        function longint unsigned span_bytes(longint unsigned first, longint unsigned len,
                                             longint unsigned bsz);
            longint unsigned nfull;
            longint unsigned ofs;
            longint unsigned lap;
            longint unsigned part;
            longint unsigned cost;
            longint unsigned tail;
            longint unsigned total;
            nfull = len / bsz;
            ofs = first % LINE_BYTES;
            lap = 0;
            part = 0;
            for (int k = 0; k < LINE_BYTES; k++) begin
                cost = lines_hit(ofs, bsz);
                lap += cost;
                if (k < nfull % LINE_BYTES) begin
                    part += cost;
                end
                ofs = (ofs + bsz) % LINE_BYTES;
            end
            total = (nfull / LINE_BYTES) * lap + part;
            tail = ((len % bsz + BUS_BYTES - 1) / BUS_BYTES) * BUS_BYTES;
            if (tail != 0) begin
                total += lines_hit((first + nfull * bsz) % LINE_BYTES, tail);
            end
            return total;
        endfunction

        function void note(logic [ADDR_BITS-1:0] addr, logic [SIZE_BITS-1:0] size,
                           logic [MODE_BITS-1:0] mode, logic store);
            longint unsigned base;
            longint unsigned last;
            longint unsigned bsz;
            longint unsigned pg_next;
            longint unsigned total;
            logic [OUT_BITS-1:0] bytes;
            base = longint'(addr);
            last = base + longint'(size);
            bsz = (mode == CW_TRANSPOSE && store) ? BSZ_SPEC : BSZ_NORM;
            total = 0;
            if (base / PAGE_BYTES != last / PAGE_BYTES) begin
                pg_next = ((base + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
                if (pg_next != base) begin
                    total += span_bytes(base - base % BUS_BYTES, pg_next - base, bsz);
                end
                total += span_bytes(pg_next - pg_next % BUS_BYTES, last - pg_next, bsz);
                crossings++;
            end else begin
                total = span_bytes(base - base % BUS_BYTES, last - (base - base % RANGE_ALIGN),
                                   bsz);
            end
            if (total >= longint'(OUT_MAX)) begin
                bytes = OUT_MAX;
                saturated++;
            end else begin
                bytes = OUT_BITS'(total);
            end
            if (mode == CW_TRANSPOSE && store) begin
                cw_stores++;
            end
            words_in++;
            expected_bytes.push_back(bytes);
        endfunction

        function void check(logic [OUT_BITS-1:0] got);
            logic [OUT_BITS-1:0] want;
            words_out++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result word %0d with nothing pending.", got);
                end
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch on result %0d: expected %0d, got %0d.",
                                 words_out, want, got);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic [ADDR_BITS-1:0]   i_base_addr;
    logic [SIZE_BITS-1:0]   i_transfer_size;
    logic [MODE_BITS-1:0]   i_transpose_mode;
    logic                   i_is_store;
    logic                   busy;
    logic                   o_valid;
    logic [OUT_BITS-1:0]    o_dram_bytes;

    dram_byte_board board = new();

    axi_burst_dram_byte_counter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_base_addr      (i_base_addr),
        .i_transfer_size  (i_transfer_size),
        .i_transpose_mode (i_transpose_mode),
        .i_is_store       (i_is_store),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_dram_bytes     (o_dram_bytes)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            board.check(o_dram_bytes);
        end
    end

    initial begin
        #(12 * 600000);
        $display("FAILURE");
        $finish;
    end

    task automatic put_word(input logic [ADDR_BITS-1:0] addr, input logic [SIZE_BITS-1:0] size,
                            input logic [MODE_BITS-1:0] mode, input logic store);
        @(negedge i_clk);
        i_base_addr      = addr;
        i_transfer_size  = size;
        i_transpose_mode = mode;
        i_is_store       = store;
        start            = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note(addr, size, mode, store);
    endtask

    task automatic rest(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start           = 1'b0;
            i_base_addr     = ADDR_BITS'({$urandom(), $urandom()});
            i_transfer_size = SIZE_BITS'($urandom());
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_word();
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_BITS-1:0] size;
        logic [MODE_BITS-1:0] mode;
        logic                 store;
        int                   pick;
        addr = ADDR_BITS'({$urandom(), $urandom()});
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            addr[PAGE_LB-1:0] = PAGE_LB'(PAGE_BYTES - 1 - $urandom_range(0, 80));
        end else if (pick < 6) begin
            addr[PAGE_LB-1:0] = PAGE_LB'($urandom_range(0, 80));
        end else if (pick == 6) begin
            addr = '1;
        end
        pick = $urandom_range(0, 15);
        if (pick < 8) begin
            size = SIZE_BITS'($urandom_range(0, 300));
        end else if (pick < 12) begin
            size = SIZE_BITS'($urandom_range(0, 9000));
        end else if (pick < 14) begin
            size = SIZE_BITS'($urandom());
        end else if (pick == 14) begin
            size = '1;
        end else begin
            size = '0;
        end
        mode  = MODE_BITS'($urandom_range(0, 3));
        store = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
            mode  = CW_TRANSPOSE;
            store = 1'b1;
        end
        put_word(addr, size, mode, store);
    endtask

    initial begin
        int sent;
        int burst_len;
        int waited;
        start            = 1'b0;
        i_rst_n          = 1'b0;
        i_base_addr      = '0;
        i_transfer_size  = '0;
        i_transpose_mode = '0;
        i_is_store       = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: extremes, every mode, page crossings and the zero-size gap.
        put_word('0, '0, 2'd0, 1'b0);
        put_word(ADDR_BITS'(5), '0, 2'd1, 1'b0);
        put_word('0, SIZE_BITS'(1), 2'd2, 1'b1);
        put_word('0, '1, CW_TRANSPOSE, 1'b1);
        put_word('0, '1, CW_TRANSPOSE, 1'b0);
        put_word('1, '1, CW_TRANSPOSE, 1'b1);
        put_word('1, '1, 2'd0, 1'b1);
        put_word('1, '0, 2'd0, 1'b0);
        put_word(ADDR_BITS'(4095), SIZE_BITS'(1), 2'd0, 1'b0);
        put_word(ADDR_BITS'(4090), SIZE_BITS'(100), 2'd1, 1'b1);
        put_word(ADDR_BITS'(4090), SIZE_BITS'(100), CW_TRANSPOSE, 1'b1);
        put_word(ADDR_BITS'(4096), SIZE_BITS'(4096), 2'd2, 1'b0);
        put_word(ADDR_BITS'(100), SIZE_BITS'(20000), 2'd0, 1'b1);
        put_word(ADDR_BITS'(100), SIZE_BITS'(20000), CW_TRANSPOSE, 1'b1);
        put_word(ADDR_BITS'(1000), SIZE_BITS'(77), CW_TRANSPOSE, 1'b0);
        put_word(ADDR_BITS'(33), SIZE_BITS'(255), 2'd1, 1'b0);
        put_word(ADDR_BITS'(48), SIZE_BITS'(257), 2'd2, 1'b1);
        put_word({ADDR_BITS{1'b1}} - ADDR_BITS'(4095), SIZE_BITS'(5000), 2'd0, 1'b0);
        put_word({ADDR_BITS{1'b1}} - ADDR_BITS'(10), SIZE_BITS'(11), CW_TRANSPOSE, 1'b1);
        put_word(ADDR_BITS'(8191), SIZE_BITS'(8193), 2'd3, 1'b0);
        drain();

        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst_len = $urandom_range(1, 24);
            repeat (burst_len) begin
                random_word();
                sent++;
            end
            if ($urandom_range(0, 30) == 0) begin
                drain();
            end else if ($urandom_range(0, 3) != 0) begin
                rest($urandom_range(1, 12));
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < 3000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        board.mismatches += board.pending();

        $display("Checked %0d of %0d transfer words: %0d crossed a page boundary,",
                 board.words_out, board.words_in, board.crossings);
        $display("%0d were CW-transpose stores and %0d hit the output ceiling.",
                 board.cw_stores, board.saturated);
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/bdc_pkg.sv
design/bdc_front.sv
design/bdc_queue.sv
design/bdc_back.sv
design/axi_burst_dram_byte_counter.sv
design/bdc_checker.sv
verif/axi_burst_dram_byte_counter_tb.sv
